[rtl/xa_adpcm_decoder_macros.svh]
// Assertion macros for the decoder's checker file.
`ifndef XA_ADPCM_DECODER_MACROS_SVH
`define XA_ADPCM_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define XAD_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define XAD_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/xad_pkg.sv]
// Shared constants, types and the predictor coefficient table of the decoder.
`default_nettype none

package xad_pkg;

   localparam int MAX_CHANNELS   = 8;
   localparam int CHAN_W         = $clog2(MAX_CHANNELS);
   localparam int ROWS_PER_BLOCK = 14;
   localparam int ROW_W          = $clog2(ROWS_PER_BLOCK + 1);
   localparam int CC_W           = 4;
   localparam int FRAME_W        = 32;
   localparam int BYTE_W         = 8;
   localparam int NIB_W          = 4;
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 10;
   localparam int PROD_W         = SAMPLE_W + COEF_W;
   localparam int SC_W           = 24;
   localparam int ACC_W          = 27;
   localparam int FRAC_W         = 8;
   localparam int Q_W            = ACC_W - FRAC_W;
   localparam int SCALE_BASE     = 20;
   localparam int ROUND_BIAS     = 128;
   localparam int SAMPLE_MAX     = 32767;
   localparam int SAMPLE_MIN     = -32768;
   localparam int COEF_SPAN      = 4;
   localparam int COEF_ENTRIES   = 20;
   localparam int COEF_IDX_W     = 5;
   localparam int DATA_W         = 32;
   localparam int ADDR_W         = 3;
   localparam int RSP_DATA_W     = 2 * SAMPLE_W;
   localparam int RSP_USER_W     = CHAN_W + 1;

   // Coefficient table: first pair index is sel, second is sel plus COEF_SPAN
   localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_ENTRIES] = '{
      10'sd0,  10'sd240,  10'sd460,  10'sd392,
      10'sd0,  10'sd0,   -10'sd208, -10'sd220,
      10'sd0,  10'sd1,    10'sd3,    10'sd4,
      10'sd7,  10'sd8,    10'sd10,   10'sd11,
      10'sd0, -10'sd1,   -10'sd3,   -10'sd4
   };

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      REG_CHANNEL_COUNT = 1'b0,
      REG_FRAME_COUNT   = 1'b1
   } xad_reg_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_HI,
      ST_ACC_HI,
      ST_MUL_LO,
      ST_ACC_LO
   } xad_state_type;

   // Configuration seen by the controller
   typedef struct packed {
      logic [CC_W-1:0]    channel_count;
      logic               start;
      logic [FRAME_W-1:0] frame_load;
   } xad_cfg_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic              clear;
      logic              load_ctl;
      logic              start;
      logic              mul;
      logic              acc;
      logic              low;
      logic [CHAN_W-1:0] ch;
      logic              second_ok;
      logic              last;
   } xad_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
   } xad_status_type;

   function automatic logic signed [COEF_W-1:0] coef_lookup(
      input logic [COEF_IDX_W-1:0] idx
   );
      logic signed [COEF_W-1:0] val;
      val = '0;
      if (idx < COEF_IDX_W'(COEF_ENTRIES)) begin
         val = COEF_TABLE[idx];
      end
      return val;
   endfunction

endpackage

`default_nettype wire

[rtl/xad_csr.sv]
// Configuration registers behind the APB-style port.
`default_nettype none

module xad_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [xad_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [xad_pkg::DATA_W-1:0]   csr_pwdata,
   output logic      [xad_pkg::DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output xad_pkg::xad_cfg_type              cfg
);

   logic [xad_pkg::CC_W-1:0]    channel_count_ff, channel_count_in;
   logic [xad_pkg::FRAME_W-1:0] frame_count_ff, frame_count_in;
   logic                        wr_en;
   xad_pkg::xad_reg_type        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = xad_pkg::xad_reg_type'(csr_paddr[2]);

   // Decode writes
   always_comb begin
      channel_count_in = channel_count_ff;
      frame_count_in   = frame_count_ff;
      if (wr_en) begin
         unique case (reg_sel)
            xad_pkg::REG_CHANNEL_COUNT: channel_count_in = csr_pwdata[xad_pkg::CC_W-1:0];
            xad_pkg::REG_FRAME_COUNT:   frame_count_in   = csr_pwdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= xad_pkg::CC_W'(1);
         frame_count_ff   <= '0;
      end else begin
         channel_count_ff <= channel_count_in;
         frame_count_ff   <= frame_count_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_sel)
         xad_pkg::REG_CHANNEL_COUNT:
            csr_prdata = xad_pkg::DATA_W'(channel_count_ff);
         xad_pkg::REG_FRAME_COUNT:
            csr_prdata = frame_count_ff;
      endcase
   end

   // Any write restarts the stream with the frame count in force after it
   assign cfg.channel_count = channel_count_ff;
   assign cfg.start         = wr_en;
   assign cfg.frame_load    = frame_count_in;

endmodule

`default_nettype wire

[rtl/xad_ctrl.sv]
// Controller: stream position counters and the per-byte sequencer.
`default_nettype none

module xad_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire xad_pkg::xad_cfg_type    cfg,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire xad_pkg::xad_status_type status,
   output xad_pkg::xad_cmd_type     cmd
);

   xad_pkg::xad_state_type          state_ff, state_in;
   logic                            in_ctl_ff, in_ctl_in;
   logic [xad_pkg::CHAN_W-1:0]      chan_ff, chan_in;
   logic [xad_pkg::ROW_W-1:0]       row_ff, row_in, row_inc;
   logic [xad_pkg::FRAME_W-1:0]     frames_ff, frames_in;
   logic [xad_pkg::CHAN_W-1:0]      last_ch, ch, ch_inc;
   logic                            accept, active, second_ok, is_last, wrap;

   // Highest channel index in use; zero acts as one, too many as the maximum
   always_comb begin
      priority if (cfg.channel_count == '0) begin
         last_ch = '0;
      end else if (cfg.channel_count > xad_pkg::CC_W'(xad_pkg::MAX_CHANNELS)) begin
         last_ch = xad_pkg::CHAN_W'(xad_pkg::MAX_CHANNELS - 1);
      end else begin
         last_ch = xad_pkg::CHAN_W'(cfg.channel_count - xad_pkg::CC_W'(1));
      end
   end

   assign ch        = (chan_ff > last_ch) ? '0 : chan_ff;
   assign ch_inc    = ch + xad_pkg::CHAN_W'(1);
   assign wrap      = (ch == last_ch);
   assign row_inc   = row_ff + xad_pkg::ROW_W'(1);
   assign accept    = (state_ff == xad_pkg::ST_IDLE) && req_tvalid;
   assign active    = (frames_ff != '0);
   assign second_ok = (frames_ff >= xad_pkg::FRAME_W'(2));
   assign is_last   = wrap && (frames_ff <= xad_pkg::FRAME_W'(2));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xad_pkg::ST_IDLE:
            if (accept && active && !in_ctl_ff) state_in = xad_pkg::ST_MUL_HI;
         xad_pkg::ST_MUL_HI: state_in = xad_pkg::ST_ACC_HI;
         xad_pkg::ST_ACC_HI: state_in = xad_pkg::ST_MUL_LO;
         xad_pkg::ST_MUL_LO: state_in = xad_pkg::ST_ACC_LO;
         xad_pkg::ST_ACC_LO:
            if (status.out_free) state_in = xad_pkg::ST_IDLE;
         default: state_in = xad_pkg::ST_IDLE;
      endcase
   end

   // Outputs: handshake and datapath commands
   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.clear     = cfg.start;
      cmd.ch        = ch;
      cmd.second_ok = second_ok;
      cmd.last      = is_last;
      unique case (state_ff)
         xad_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && active) begin
               cmd.load_ctl = in_ctl_ff;
               cmd.start    = !in_ctl_ff;
            end
         end
         xad_pkg::ST_MUL_HI: cmd.mul = 1'b1;
         xad_pkg::ST_ACC_HI: cmd.acc = 1'b1;
         xad_pkg::ST_MUL_LO: begin
            cmd.mul = 1'b1;
            cmd.low = 1'b1;
         end
         xad_pkg::ST_ACC_LO: begin
            cmd.acc = status.out_free;
            cmd.low = 1'b1;
         end
         default: ;
      endcase
   end

   // Load on restart; step channel, row, frames on accepted words if active
   always_comb begin
      in_ctl_in = in_ctl_ff;
      chan_in   = chan_ff;
      row_in    = row_ff;
      frames_in = frames_ff;
      if (cfg.start) begin
         in_ctl_in = 1'b1;
         chan_in   = '0;
         row_in    = '0;
         frames_in = cfg.frame_load;
      end else if (accept && active) begin
         chan_in = wrap ? '0 : ch_inc;
         if (wrap) begin
            if (in_ctl_ff) begin
               row_in    = '0;
               in_ctl_in = 1'b0;
            end else begin
               frames_in = second_ok ? frames_ff - xad_pkg::FRAME_W'(2) : '0;
               if (row_inc >= xad_pkg::ROW_W'(xad_pkg::ROWS_PER_BLOCK)) begin
                  row_in    = '0;
                  in_ctl_in = 1'b1;
               end else begin
                  row_in = row_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= xad_pkg::ST_IDLE;
         in_ctl_ff <= 1'b1;
         chan_ff   <= '0;
         row_ff    <= '0;
         frames_ff <= '0;
      end else begin
         state_ff  <= state_in;
         in_ctl_ff <= in_ctl_in;
         chan_ff   <= chan_in;
         row_ff    <= row_in;
         frames_ff <= frames_in;
      end
   end

endmodule

`default_nettype wire

[rtl/xad_dpath.sv]
// Datapath: per-channel history, predictor multiply-accumulate and result register.
`default_nettype none

module xad_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire xad_pkg::xad_cmd_type              cmd,
   input  wire logic [xad_pkg::BYTE_W-1:0]        req_tdata,
   output xad_pkg::xad_status_type                status,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [xad_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic      [xad_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                                   rsp_tlast
);

   // Per-channel block header and history
   logic        [xad_pkg::NIB_W-1:0]    shift_mem_ff [xad_pkg::MAX_CHANNELS];
   logic        [xad_pkg::NIB_W-1:0]    sel_mem_ff   [xad_pkg::MAX_CHANNELS];
   logic signed [xad_pkg::SAMPLE_W-1:0] prev_hist_ff [xad_pkg::MAX_CHANNELS];
   logic signed [xad_pkg::SAMPLE_W-1:0] cur_hist_ff  [xad_pkg::MAX_CHANNELS];

   // Working registers of the byte in flight
   logic        [xad_pkg::BYTE_W-1:0]   byte_ff;
   logic        [xad_pkg::CHAN_W-1:0]   ch_ff;
   logic                                ok_ff, last_ff;
   logic        [xad_pkg::NIB_W-1:0]    sh_ff;
   logic signed [xad_pkg::COEF_W-1:0]   c1_ff, c2_ff;
   logic signed [xad_pkg::SAMPLE_W-1:0] cur_w_ff, prev_w_ff, s1_ff;
   logic signed [xad_pkg::PROD_W-1:0]   p1_ff, p2_ff, p1_in, p2_in;
   logic signed [xad_pkg::SC_W-1:0]     sc_ff, sc_in;

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [xad_pkg::SAMPLE_W-1:0] rsp_first_ff, rsp_second_ff;
   logic        [xad_pkg::CHAN_W-1:0]   rsp_ch_ff;
   logic                                rsp_ok_ff, rsp_last_ff;

   logic        [xad_pkg::NIB_W-1:0]      sel_rd;
   logic signed [xad_pkg::NIB_W-1:0]      nib;
   logic        [xad_pkg::COEF_IDX_W-1:0] shamt;
   logic signed [xad_pkg::ACC_W-1:0]      sum;
   logic signed [xad_pkg::Q_W-1:0]        quo;
   logic signed [xad_pkg::SAMPLE_W-1:0]   v;
   logic                                  commit;

   assign sel_rd = sel_mem_ff[cmd.ch];
   assign commit = cmd.acc && cmd.low;

   // Scale the nibble and form both predictor products
   assign nib   = cmd.low ? byte_ff[xad_pkg::NIB_W-1:0]
                          : byte_ff[xad_pkg::BYTE_W-1:xad_pkg::NIB_W];
   assign shamt = xad_pkg::COEF_IDX_W'(xad_pkg::SCALE_BASE) - {1'b0, sh_ff};
   assign sc_in = xad_pkg::SC_W'(nib) <<< shamt;
   assign p1_in = xad_pkg::PROD_W'(cur_w_ff) * xad_pkg::PROD_W'(c1_ff);
   assign p2_in = xad_pkg::PROD_W'(prev_w_ff) * xad_pkg::PROD_W'(c2_ff);

   // Sum with rounding bias, floor shift and clip
   assign sum = xad_pkg::ACC_W'(p1_ff) + xad_pkg::ACC_W'(p2_ff) + xad_pkg::ACC_W'(sc_ff)
              + xad_pkg::ACC_W'(xad_pkg::ROUND_BIAS);
   assign quo = sum[xad_pkg::ACC_W-1:xad_pkg::FRAC_W];

   always_comb begin
      priority if (quo >= xad_pkg::Q_W'(xad_pkg::SAMPLE_MAX)) begin
         v = xad_pkg::SAMPLE_W'(xad_pkg::SAMPLE_MAX);
      end else if (quo <= xad_pkg::Q_W'(xad_pkg::SAMPLE_MIN)) begin
         v = xad_pkg::SAMPLE_W'(xad_pkg::SAMPLE_MIN);
      end else begin
         v = quo[xad_pkg::SAMPLE_W-1:0];
      end
   end

   // Store block header bytes
   always_ff @(posedge clock) begin
      if (cmd.load_ctl) begin
         shift_mem_ff[cmd.ch] <= req_tdata[xad_pkg::NIB_W-1:0];
         sel_mem_ff[cmd.ch]   <= req_tdata[xad_pkg::BYTE_W-1:xad_pkg::NIB_W];
      end
   end

   // Keep sample history; zero it on reset and stream restart
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < xad_pkg::MAX_CHANNELS; i++) begin
            prev_hist_ff[i] <= '0;
            cur_hist_ff[i]  <= '0;
         end
      end else if (commit) begin
         prev_hist_ff[ch_ff] <= cur_w_ff;
         cur_hist_ff[ch_ff]  <= v;
      end
   end

   // Load the byte, run the two passes for each nibble
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         byte_ff   <= req_tdata;
         ch_ff     <= cmd.ch;
         ok_ff     <= cmd.second_ok;
         last_ff   <= cmd.last;
         sh_ff     <= shift_mem_ff[cmd.ch];
         c1_ff     <= xad_pkg::coef_lookup({1'b0, sel_rd});
         c2_ff     <= xad_pkg::coef_lookup({1'b0, sel_rd}
                                           + xad_pkg::COEF_IDX_W'(xad_pkg::COEF_SPAN));
         cur_w_ff  <= cur_hist_ff[cmd.ch];
         prev_w_ff <= prev_hist_ff[cmd.ch];
      end else if (cmd.acc) begin
         prev_w_ff <= cur_w_ff;
         cur_w_ff  <= v;
      end
      if (cmd.mul) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         sc_ff <= sc_in;
      end
      if (cmd.acc && !cmd.low) begin
         s1_ff <= v;
      end
   end

   // Result register: fill on commit, drain on handshake
   assign rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_first_ff  <= s1_ff;
         rsp_second_ff <= v;
         rsp_ch_ff     <= ch_ff;
         rsp_ok_ff     <= ok_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {rsp_second_ff, rsp_first_ff};
   assign rsp_tuser       = {rsp_ok_ff, rsp_ch_ff};
   assign rsp_tlast       = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/xa_adpcm_decoder.sv]
// Top level of the XA ADPCM byte-stream decoder.
//
// req_*: one compressed byte per word. Each block opens with one control
// byte per channel, then 14 rows of one sample byte per channel.
// rsp_*: one word per sample byte: two decoded 16-bit samples, the channel,
// a flag for the second sample and tlast on the final word of the stream.
// csr_*: channel_count at 0x0 and frame_count at 0x4; any write restarts
// the stream: history cleared, next byte is a control byte.
// A control byte is stored and leaves the input ready. A sample byte keeps
// the input busy through ST_MUL_HI, ST_ACC_HI, ST_MUL_LO and ST_ACC_LO:
// each nibble takes a multiply pass and an accumulate pass through the
// shared predictor multipliers; the result word is registered in the last pass.
// Reset clears history, sets channel_count to 1 and frame_count to 0; bytes
// are then accepted and dropped until a nonzero frame count is written.
// Once the frame count runs out, further bytes are accepted and dropped.
// If the receiver stalls, the result register holds its word; the next
// byte is still taken and decoded, and it waits in its last pass until the
// register frees up.
`default_nettype none

module xa_adpcm_decoder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,    // [7:0] data_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [31:0]  rsp_tdata,    // [15:0] sample_first, [31:16] sample_second
   output logic      [3:0]   rsp_tuser,    // [2:0] channel_index, [3] second_valid
   output logic              rsp_tlast,    // last
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic      [31:0]  csr_prdata,
   output logic              csr_pready
);

   xad_pkg::xad_cfg_type    cfg;
   xad_pkg::xad_cmd_type    cmd;
   xad_pkg::xad_status_type status;

   xad_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   xad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   xad_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/xad_checker.sv]
// Port-level checks of the decoder, bound to its top level.
`default_nettype none
`include "xa_adpcm_decoder_macros.svh"

module xad_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result word holds
   `XAD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result word changed")

   // A new result only comes out of a byte that kept the input busy
   `XAD_ASSERT_IMPL(a_rsp_after_busy, $rose(rsp_tvalid), !$past(req_tready, 1) && !$past(req_tready, 4), "result word without a decoded byte")

   // The input goes busy only by taking a word
   `XAD_ASSERT_IMPL(a_busy_on_accept, $fell(req_tready), $past(req_tvalid), "input went busy without a word")

endmodule

bind xa_adpcm_decoder xad_port_checker u_checker (.*);

`default_nettype wire
